FILE: rtl/core/xrid_pkg.sv
package xrid_pkg;

    // request and result field widths
    localparam int LEN_W  = 7;
    localparam int CHAR_W = 7;

    // longest identifier handed out for one request
    localparam int MAX_ID_LENGTH = 64;
    localparam int LEFT_W        = $clog2(MAX_ID_LENGTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_SMALL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_LARGE = 2'd2;

    // generator mode codes
    localparam logic MODE_SMALL = 1'b0;
    localparam logic MODE_LARGE = 1'b1;

    localparam logic [31:0] SEED_SMALL_RESET = 32'd2463534242;
    localparam logic [63:0] SEED_LARGE_RESET = 64'd88172645463325252;

    // modulo reduction: 6-bit digits, 64 = 3 (mod 61)
    localparam int DIGIT_W   = 6;
    localparam int DIGITS    = (64 + DIGIT_W - 1) / DIGIT_W;
    localparam int WORD_W    = DIGITS * DIGIT_W;
    localparam int DCNT_W    = $clog2(DIGITS);
    localparam int MODULUS   = 61;
    localparam int REM_W     = 6;

    // status of the modulo unit
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [REM_W-1:0] rem;
    } t_mod_status;

    // one 32-bit xorshift step, shifts 13, 17, 5
    function automatic logic [31:0] next_small(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

    // one 64-bit xorshift step, shifts 13, 7, 17
    function automatic logic [63:0] next_large(input logic [63:0] x);
        logic [63:0] a;
        logic [63:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 7);
        return b ^ (b >> 17);
    endfunction

    // remainder to ascii: digits, then 'b'..'z', then 'A'..'Z'
    function automatic logic [CHAR_W-1:0] map_char(input logic [REM_W-1:0] r);
        logic [CHAR_W-1:0] rw;
        rw = CHAR_W'(r);
        if (r < REM_W'(10)) begin
            return CHAR_W'(48) + rw;
        end else if (r < REM_W'(35)) begin
            return CHAR_W'(88) + rw;
        end
        return CHAR_W'(30) + rw;
    endfunction

endpackage

FILE: rtl/core/xrid_if.sv
// request channel
interface xrid_req_if;
    logic                       valid;
    logic                       ready;
    logic [xrid_pkg::LEN_W-1:0] id_length;

    modport source (output valid, output id_length, input ready);
    modport sink   (input valid, input id_length, output ready);
endinterface

// result channel, one character per transfer
interface xrid_res_if;
    logic                        valid;
    logic                        ready;
    logic [xrid_pkg::CHAR_W-1:0] id_char;
    logic                        last_char;

    modport source (output valid, output id_char, output last_char, input ready);
    modport sink   (input valid, input id_char, input last_char, output ready);
endinterface

// configuration write channel
interface xrid_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [xrid_pkg::CFG_IDX_W-1:0]  index;
    logic [xrid_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/xrid_mod61.sv
module xrid_mod61 (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [63:0]           i_word,
    output xrid_pkg::t_mod_status o_status
);
    import xrid_pkg::*;

    logic [WORD_W-1:0]  r_word, n_word;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [DCNT_W-1:0]  r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;

    logic [DIGIT_W-1:0] digit;
    logic [7:0]         acc;
    logic [REM_W-1:0]   acc_red;

    // horner step: rem = (3 * rem + digit) mod 61, acc stays below 4 * 61
    assign digit = r_word[WORD_W-1 -: DIGIT_W];
    assign acc   = 8'({r_rem, 1'b0}) + 8'(r_rem) + 8'(digit);

    always_comb begin
        priority if (acc >= 8'(3 * MODULUS)) begin
            acc_red = REM_W'(acc - 8'(3 * MODULUS));
        end else if (acc >= 8'(2 * MODULUS)) begin
            acc_red = REM_W'(acc - 8'(2 * MODULUS));
        end else if (acc >= 8'(MODULUS)) begin
            acc_red = REM_W'(acc - 8'(MODULUS));
        end else begin
            acc_red = REM_W'(acc);
        end
    end

    // digit sequencer, most significant digit first
    always_comb begin
        n_word = r_word;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_word = WORD_W'(i_word);
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_word = r_word << DIGIT_W;
            n_rem  = acc_red;
            n_cnt  = r_cnt + DCNT_W'(1);
            if (r_cnt == DCNT_W'(DIGITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_rem  <= n_rem;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_status.rem  = r_rem;

endmodule

FILE: rtl/core/xorshift_random_id_chars_unit.sv
// channel  | modport | fields                 | role
// i_req    | sink    | id_length              | identifier request
// o_res    | source  | id_char, last_char     | one character per result
// i_cfg    | sink    | index, data            | mode and seed writes
//
// each character passes through a draw, eleven digit steps of the
// shared mod 61 unit, a turn to pick up the remainder and a hand-off.
// a new request is accepted only after the last character of the previous
// one is handed off; length 0 is accepted and yields no characters.
// i_rst_n is synchronous: both generators reload their reset seeds.
// a stalled output holds the character; the next hand-off waits for space.
module xorshift_random_id_chars_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xrid_req_if.sink   i_req,
    xrid_res_if.source o_res,
    xrid_cfg_if.sink   i_cfg
);
    import xrid_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DRAW = 2'd1;
    localparam logic [1:0] ST_RED  = 2'd2;
    localparam logic [1:0] ST_PUT  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [LEFT_W-1:0] r_left, n_left;
    logic              r_mode, n_mode;
    logic [31:0]       r_gen_small, n_gen_small;
    logic [63:0]       r_gen_large, n_gen_large;
    logic              r_out_valid, n_out_valid;
    logic [CHAR_W-1:0] r_out_char, n_out_char;
    logic              r_out_last, n_out_last;

    logic              req_acc;
    logic              cfg_acc;
    logic              out_free;
    logic [LEFT_W-1:0] len_sat;
    logic [31:0]       draw_small;
    logic [63:0]       draw_large;
    logic              mod_start;
    logic [63:0]       mod_word;
    t_mod_status       s_mod;

    assign req_acc  = i_req.valid && i_req.ready;
    assign cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign out_free = !r_out_valid || o_res.ready;

    assign i_req.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = (r_state == ST_IDLE);

    // saturate the requested length
    always_comb begin
        if (int'(i_req.id_length) > MAX_ID_LENGTH) begin
            len_sat = LEFT_W'(MAX_ID_LENGTH);
        end else begin
            len_sat = LEFT_W'(i_req.id_length);
        end
    end

    assign draw_small = next_small(r_gen_small);
    assign draw_large = next_large(r_gen_large);

    assign mod_start = (r_state == ST_DRAW);
    assign mod_word  = (r_mode == MODE_LARGE) ? draw_large : 64'(draw_small);

    xrid_mod61 u_mod61 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mod_start),
        .i_word   (mod_word),
        .o_status (s_mod)
    );

    // sequencer, generators and output register
    always_comb begin
        n_state     = r_state;
        n_left      = r_left;
        n_mode      = r_mode;
        n_gen_small = r_gen_small;
        n_gen_large = r_gen_large;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (req_acc && (len_sat != '0)) begin
                    n_left  = len_sat;
                    n_state = ST_DRAW;
                end
            end
            ST_DRAW: begin
                if (r_mode == MODE_LARGE) begin
                    n_gen_large = draw_large;
                end else begin
                    n_gen_small = draw_small;
                end
                n_state = ST_RED;
            end
            ST_RED: begin
                if (s_mod.done) begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = map_char(s_mod.rem);
                    n_out_last  = (r_left == LEFT_W'(1));
                    n_left      = r_left - LEFT_W'(1);
                    n_state     = (r_left == LEFT_W'(1)) ? ST_IDLE : ST_DRAW;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // register writes, taken only while idle
        if (cfg_acc) begin
            unique case (i_cfg.index)
                CFG_MODE: begin
                    n_mode = i_cfg.data[0];
                end
                CFG_SEED_SMALL: begin
                    n_gen_small = i_cfg.data[31:0];
                end
                CFG_SEED_LARGE: begin
                    n_gen_large = i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_left      <= '0;
            r_mode      <= MODE_SMALL;
            r_gen_small <= SEED_SMALL_RESET;
            r_gen_large <= SEED_LARGE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_mode      <= n_mode;
            r_gen_small <= n_gen_small;
            r_gen_large <= n_gen_large;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.id_char   = r_out_char;
    assign o_res.last_char = r_out_last;

    // no characters owed while waiting for a request
    a_idle_no_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_left == '0))
        else $error("characters still owed in idle");

    // the modulo unit finishes only while the sequencer waits for it
    a_done_in_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_mod.done |-> (r_state == ST_RED))
        else $error("modulo result outside reduction wait");

    // a non-empty request starts a draw
    a_req_draws: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && (len_sat != '0)) |=> (r_state == ST_DRAW))
        else $error("request did not start a draw");

    // the modulo unit is never restarted while busy
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_start |-> !s_mod.busy)
        else $error("modulo unit restarted while busy");

endmodule

FILE: tb/sv/tb_xorshift_random_id_chars_unit.sv
`timescale 1ns / 1ps

module tb_xorshift_random_id_chars_unit;
    import xrid_pkg::*;

    // spare register index, writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_id_char;

    logic i_clk;
    logic i_rst_n;

    xrid_req_if req_ch ();
    xrid_res_if res_ch ();
    xrid_cfg_if cfg_ch ();

    xorshift_random_id_chars_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // predictor state, mirrors the block's generators and mode
    logic        pred_mode;
    logic [31:0] gen32_state;
    logic [63:0] gen64_state;

    t_id_char pending_chars[$];
    int       fail_count;
    bit       idle_on;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // 32-bit xorshift step, shifts 13, 17, 5
    function automatic logic [31:0] xs32_advance(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        return t ^ (t << 5);
    endfunction

    // 64-bit xorshift step, shifts 13, 7, 17
    function automatic logic [63:0] xs64_advance(input logic [63:0] s);
        logic [63:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 7);
        return t ^ (t >> 17);
    endfunction

    // remainder mod 61 to ascii: digits, 'b'..'z', 'A'..'Z'
    function automatic logic [CHAR_W-1:0] remainder_to_char(input int unsigned r);
        if (r < 10) return CHAR_W'(48 + r);
        if (r < 35) return CHAR_W'(97 + r - 9);
        return CHAR_W'(65 + r - 35);
    endfunction

    // expected characters for one accepted request
    task automatic predict_id_chars(input logic [LEN_W-1:0] len);
        int unsigned n;
        int unsigned r;
        t_id_char    e;
        n = (len > MAX_ID_LENGTH) ? MAX_ID_LENGTH : len;
        for (int unsigned k = 0; k < n; k++) begin
            if (pred_mode == MODE_SMALL) begin
                gen32_state = xs32_advance(gen32_state);
                r = int'(gen32_state % 32'(MODULUS));
            end else begin
                gen64_state = xs64_advance(gen64_state);
                r = int'(gen64_state % 64'(MODULUS));
            end
            e.ch   = remainder_to_char(r);
            e.last = (k == n - 1);
            pending_chars.push_back(e);
        end
    endtask

    // random length, mostly short, some at and above the cap
    function automatic logic [LEN_W-1:0] pick_length();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return '0;
        if (sel <= 2) return LEN_W'(MAX_ID_LENGTH);
        if (sel <= 4) return LEN_W'($urandom_range(MAX_ID_LENGTH + 1, 127));
        if (sel <= 7) return LEN_W'($urandom_range(17, MAX_ID_LENGTH - 1));
        return LEN_W'($urandom_range(1, 16));
    endfunction

    // seed with a bias towards the extremes
    function automatic logic [63:0] pick_seed();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return {$urandom, $urandom};
            end
        endcase
    endfunction

    // mode word with junk in the unused upper bits
    function automatic logic [63:0] mode_word(input logic m);
        logic [63:0] w;
        w    = {$urandom, $urandom};
        w[0] = m;
        return w;
    endfunction

    // one request on the id channel, with an optional gap first
    task automatic send_request(input logic [LEN_W-1:0] len);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.id_length <= len;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_id_chars(len);
    endtask

    // register write, only issued while the block is idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_MODE: begin
                pred_mode = data[0];
            end
            CFG_SEED_SMALL: begin
                gen32_state = data[31:0];
            end
            CFG_SEED_LARGE: begin
                gen64_state = data;
            end
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    // hold requests until every character is back, then let the block settle
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // reset seeds in mode 0: cap, zero length, saturation, single char
    task automatic test_reset_state();
        send_request(LEN_W'(MAX_ID_LENGTH));
        send_request('0);
        send_request('1);
        send_request(LEN_W'(1));
        wait_idle();
    endtask

    // 64-bit generator from its reset seed
    task automatic test_large_generator();
        cfg_write(CFG_MODE, mode_word(MODE_LARGE));
        send_request(LEN_W'(1));
        send_request(LEN_W'(3));
        wait_idle();
    endtask

    // seed extremes, zero seeds, spare index, untouched idle generator
    task automatic test_seed_loading();
        cfg_write(CFG_MODE, mode_word(MODE_SMALL));
        cfg_write(CFG_SEED_SMALL, {$urandom, 32'hFFFF_FFFF});
        send_request(LEN_W'(2));
        wait_idle();
        cfg_write(CFG_SEED_SMALL, {$urandom, 32'h0000_0000});
        send_request(LEN_W'(2));
        wait_idle();
        cfg_write(CFG_MODE, mode_word(MODE_LARGE));
        cfg_write(CFG_SEED_LARGE, '1);
        send_request(LEN_W'(2));
        wait_idle();
        cfg_write(CFG_SEED_LARGE, '0);
        send_request(LEN_W'(2));
        wait_idle();
        cfg_write(CFG_SEED_SMALL, {$urandom, $urandom});
        cfg_write(CFG_SEED_LARGE, {$urandom, $urandom});
        cfg_write(CFG_UNUSED, {$urandom, $urandom});
        send_request(LEN_W'(2));
        wait_idle();
        cfg_write(CFG_MODE, mode_word(MODE_SMALL));
        send_request(LEN_W'(2));
        wait_idle();
    endtask

    // random settings per phase, random lengths, an occasional full drain
    task automatic test_random_traffic(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++) begin
            cfg_write(CFG_MODE, mode_word(logic'($urandom_range(0, 1))));
            if ($urandom_range(0, 1)) cfg_write(CFG_SEED_SMALL, pick_seed());
            if ($urandom_range(0, 1)) cfg_write(CFG_SEED_LARGE, pick_seed());
            if ($urandom_range(0, 3) == 0) cfg_write(CFG_UNUSED, {$urandom, $urandom});
            for (int i = 0; i < per_phase; i++) begin
                send_request(pick_length());
                if ($urandom_range(0, 19) == 0) wait_idle();
            end
            wait_idle();
        end
    endtask

    // back-to-back traffic with no gaps on either side
    task automatic test_unpaused_tail(input int count);
        idle_on = 1'b0;
        cfg_write(CFG_SEED_SMALL, {$urandom, $urandom});
        cfg_write(CFG_SEED_LARGE, {$urandom, $urandom});
        cfg_write(CFG_MODE, mode_word(logic'($urandom_range(0, 1))));
        for (int i = 0; i < count; i++) send_request(pick_length());
        wait_idle();
    endtask

    // result ready with random stall bursts
    initial begin : res_ready_drive
        int burst;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 5);
                res_ch.ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    // compare each character with the oldest expectation
    always @(posedge i_clk) begin : char_checker
        t_id_char want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_chars.size() == 0) begin
                if (fail_count < REPORT_LIMIT) begin
                    $display("unexpected character %0d last %0b",
                             res_ch.id_char, res_ch.last_char);
                end
                fail_count++;
            end else begin
                want = pending_chars.pop_front();
                if (res_ch.id_char !== want.ch || res_ch.last_char !== want.last) begin
                    if (fail_count < REPORT_LIMIT) begin
                        $display("mismatch: expected char %0d last %0b, got char %0d last %0b",
                                 want.ch, want.last, res_ch.id_char, res_ch.last_char);
                    end
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    // reset, tests in turn, final verdict
    initial begin
        req_ch.valid     <= 1'b0;
        req_ch.id_length <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= '0;
        cfg_ch.data      <= '0;
        i_rst_n          <= 1'b0;
        pred_mode   = MODE_SMALL;
        gen32_state = SEED_SMALL_RESET;
        gen64_state = SEED_LARGE_RESET;
        fail_count  = 0;
        idle_on     = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_large_generator();
        test_seed_loading();
        test_random_traffic(5, 25);
        test_unpaused_tail(25);

        fail_count += pending_chars.size();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/xrid_pkg.sv
rtl/core/xrid_if.sv
rtl/core/xrid_mod61.sv
rtl/core/xorshift_random_id_chars_unit.sv
tb/sv/tb_xorshift_random_id_chars_unit.sv
